/* sv/tbp_pkg.sv */
`default_nettype none

package tbp_pkg;

  // default table geometry
  localparam int GLOBAL_HIST_LEN_DEF = 12;
  localparam int LOCAL_HIST_LEN_DEF  = 10;
  localparam int PC_SELECT_BITS_DEF  = 10;

  // lowest branch address bit used to pick a local history
  localparam int PC_LSB = 2;

  // request codes
  localparam logic OP_PREDICT = 1'b0;
  localparam logic OP_UPDATE  = 1'b1;

  // two-bit saturating counters
  localparam logic [1:0] CTR_MIN        = 2'd0;
  localparam logic [1:0] CTR_MAX        = 2'd3;
  localparam logic [1:0] LOCAL_CTR_RST  = 2'd1;
  localparam logic [1:0] GLOBAL_CTR_RST = 2'd3;
  localparam logic [1:0] CHOICE_CTR_RST = 2'd3;

  typedef struct packed {
    logic        op;
    logic [31:0] pc;
    logic        cond_branch;
    logic        taken;
  } in_req_t;

  typedef struct packed {
    logic prediction;
    logic local_guess;
    logic global_guess;
    logic used_global;
  } out_rsp_t;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic capture;
    logic read_ctr;
    logic commit;
  } tbp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic out_free;
  } tbp_sts_t;

  function automatic logic [1:0] ctr_train(input logic [1:0] c, input logic up);
    logic [1:0] r;
    r = c;
    if (up) begin
      if (c != CTR_MAX) r = c + 2'd1;
    end else begin
      if (c != CTR_MIN) r = c - 2'd1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* sv/tbp_ctrl.sv */
`default_nettype none

module tbp_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire tbp_pkg::tbp_sts_t sts_i,
  output tbp_pkg::tbp_cmd_t     cmd_o
);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_HIST  = 4'b0100,
    S_CTR   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_HIST;
        end
      end
      S_HIST: begin
        cmd_o.read_ctr = 1'b1;
        state_d        = S_CTR;
      end
      S_CTR: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

/* sv/tbp_datapath.sv */
`default_nettype none

module tbp_datapath #(
  parameter int GLOBAL_HIST_LEN = tbp_pkg::GLOBAL_HIST_LEN_DEF,
  parameter int LOCAL_HIST_LEN  = tbp_pkg::LOCAL_HIST_LEN_DEF,
  parameter int PC_SELECT_BITS  = tbp_pkg::PC_SELECT_BITS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire tbp_pkg::in_req_t  in_req_i,
  input  wire tbp_pkg::tbp_cmd_t cmd_i,
  output tbp_pkg::tbp_sts_t      sts_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output tbp_pkg::out_rsp_t      out_rsp_o
);

  localparam int G = GLOBAL_HIST_LEN;
  localparam int L = LOCAL_HIST_LEN;
  localparam int P = PC_SELECT_BITS;
  localparam int GL_MAX = (G > L) ? G : L;
  localparam int CLR_W  = (GL_MAX > P) ? GL_MAX : P;

  // tables
  logic [L-1:0] lht_mem [2**P];
  logic [1:0]   lc_mem  [2**L];
  logic [1:0]   gc_mem  [2**G];
  logic [1:0]   ch_mem  [2**G];

  logic [CLR_W-1:0] clr_idx_q;
  logic [G-1:0]     ghist_q;
  tbp_pkg::in_req_t req_q;
  logic [P-1:0]     sel_q;
  logic [L-1:0]     lhist_q;
  logic [1:0]       lc_q, gc_q, ch_q;
  logic             out_valid_q;
  tbp_pkg::out_rsp_t out_q;

  logic [P-1:0] sel_in;
  logic         lg, gg, ug, upd;
  logic [L:0]   lh_shift;
  logic [G:0]   gh_shift;

  assign sel_in   = in_req_i.pc[tbp_pkg::PC_LSB +: P];
  assign lg       = lc_q[1];
  assign gg       = gc_q[1];
  assign ug       = ch_q[1];
  assign upd      = cmd_i.commit && (req_q.op == tbp_pkg::OP_UPDATE);
  assign lh_shift = {lhist_q, req_q.taken};
  assign gh_shift = {ghist_q, req_q.taken};

  assign sts_o.clear_last = &clr_idx_q;
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_idx_q <= '0;
    end else if (cmd_i.clear) begin
      clr_idx_q <= clr_idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ghist_q <= '0;
    end else if (upd) begin
      ghist_q <= gh_shift[G-1:0];
    end
  end

  // request capture and local history read
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q   <= in_req_i;
      sel_q   <= sel_in;
      lhist_q <= lht_mem[sel_in];
    end
  end

  // counter reads
  always_ff @(posedge clk_i) begin
    if (cmd_i.read_ctr) begin
      lc_q <= lc_mem[lhist_q];
      gc_q <= gc_mem[ghist_q];
      ch_q <= ch_mem[ghist_q];
    end
  end

  // table writes: clearing sweep, then training
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      lht_mem[clr_idx_q[P-1:0]] <= '0;
    end else if (upd) begin
      lht_mem[sel_q] <= lh_shift[L-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      lc_mem[clr_idx_q[L-1:0]] <= tbp_pkg::LOCAL_CTR_RST;
    end else if (upd) begin
      lc_mem[lhist_q] <= tbp_pkg::ctr_train(lc_q, req_q.taken);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      gc_mem[clr_idx_q[G-1:0]] <= tbp_pkg::GLOBAL_CTR_RST;
    end else if (upd) begin
      gc_mem[ghist_q] <= tbp_pkg::ctr_train(gc_q, req_q.taken);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      ch_mem[clr_idx_q[G-1:0]] <= tbp_pkg::CHOICE_CTR_RST;
    end else if (upd && (lg != gg)) begin
      ch_mem[ghist_q] <= tbp_pkg::ctr_train(ch_q, gg == req_q.taken);
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_q.prediction   <= req_q.cond_branch && (ug ? gg : lg);
      out_q.local_guess  <= lg;
      out_q.global_guess <= gg;
      out_q.used_global  <= ug;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

`default_nettype wire

/* sv/tournament_branch_predictor_top.sv */
// a request is captured with its local history, then its counters are read, then its result
// is registered and the tables are trained once the result register is free; no new request is taken before then
// result register lets the next request enter while a result waits to be taken
// reset: asynchronous, active low; a clearing sweep with a max(global, local,
// select)-bit index follows, with requests stalled throughout
`default_nettype none

module tournament_branch_predictor_top #(
  parameter int GLOBAL_HIST_LEN = tbp_pkg::GLOBAL_HIST_LEN_DEF,
  parameter int LOCAL_HIST_LEN  = tbp_pkg::LOCAL_HIST_LEN_DEF,
  parameter int PC_SELECT_BITS  = tbp_pkg::PC_SELECT_BITS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // request channel
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire tbp_pkg::in_req_t in_req_i,
  // result channel
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output tbp_pkg::out_rsp_t     out_rsp_o
);

  // command and status between sequencer and datapath
  tbp_pkg::tbp_cmd_t cmd;
  tbp_pkg::tbp_sts_t sts;

  // sequencer: clearing sweep, then capture, counter read and commit per request
  tbp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // tables, histories and the result register
  tbp_datapath #(
    .GLOBAL_HIST_LEN (GLOBAL_HIST_LEN),
    .LOCAL_HIST_LEN  (LOCAL_HIST_LEN),
    .PC_SELECT_BITS  (PC_SELECT_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

`default_nettype wire

/* sv/tbp_checker.sv */
`default_nettype none

module tbp_assert (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire tbp_pkg::in_req_t  in_req_i,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire tbp_pkg::out_rsp_t out_rsp_o
);

  // held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("result changed while stalled");

  // one request in flight at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while another in flight");

  // final guess follows the choice
  a_pred_sel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.prediction |->
      (out_rsp_o.used_global && out_rsp_o.global_guess) ||
      (!out_rsp_o.used_global && out_rsp_o.local_guess))
    else $error("prediction disagrees with selected guess");

  // tables are being cleared straight after reset
  a_clear_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> in_stall_o && !out_valid_o)
    else $error("requests taken during clearing");

endmodule

bind tournament_branch_predictor_top tbp_assert u_tbp_assert (.*);

`default_nettype wire
